/* rtl/core/ray_voxel_face_pick_defines.svh */
// Assertion macros for the ray/voxel face picker.
// RVFP_ASSERT_IMPL: same-cycle implication. RVFP_ASSERT_NEXT: next-cycle implication.
`ifndef RAY_VOXEL_FACE_PICK_DEFINES_SVH
`define RAY_VOXEL_FACE_PICK_DEFINES_SVH
`ifndef SYNTH
`define RVFP_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("assertion failed");
`define RVFP_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define RVFP_ASSERT_IMPL(lbl, ck, rn, ante, cons)
`define RVFP_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

/* rtl/core/rvfp_pkg.sv */
package rvfp_pkg;

  localparam int COORD_BITS    = 16;
  localparam int FRAC_BITS     = 16;
  localparam int ORG_BITS      = 32;
  localparam int DIR_BITS      = 16;
  localparam int DIR_FRAC      = 14;
  localparam int MARGIN_BITS   = 17;
  localparam int DIST_BITS     = 31;
  localparam int NB_BITS       = COORD_BITS + 1;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;

  // scaled coordinate differences, products and sums
  localparam int CS_W  = COORD_BITS + 2 + FRAC_BITS;
  localparam int SCL_W = ((CS_W > ORG_BITS) ? CS_W : ORG_BITS) + 3;
  localparam int DEN_W = DIR_BITS + 1;
  localparam int PRD_W = SCL_W + DEN_W;
  localparam int SUM_W = PRD_W + 2;

  localparam logic [2:0] FACE_NONE = 3'd6;

  localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_X    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_Y    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_Z    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_DIR_X       = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_DIR_Y       = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_DIR_Z       = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_EDGE_MARGIN = 3'd6;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [ORG_BITS-1:0]   org_t;
  typedef logic [DIR_BITS-1:0]   dir_t;
  typedef logic [DEN_W-1:0]      den_t;
  typedef logic [SCL_W-1:0]      scl_t;
  typedef logic [PRD_W-1:0]      prd_t;
  typedef logic [SUM_W-1:0]      sum_t;
  typedef logic [NB_BITS-1:0]    nb_t;

  typedef struct packed {
    coord_t cube_x;
    coord_t cube_y;
    coord_t cube_z;
  } in_word_t;

  typedef struct packed {
    logic                 hit;
    logic [DIST_BITS-1:0] center_distance;
    logic [2:0]           face_index;
    nb_t                  neighbor_x;
    nb_t                  neighbor_y;
    nb_t                  neighbor_z;
  } out_word_t;

  typedef struct packed {
    org_t [2:0]             org;
    dir_t [2:0]             dir;
    logic [MARGIN_BITS-1:0] margin;
  } cfg_t;

  localparam dir_t DIR_Z_RST = 16'(16384);
  localparam cfg_t CFG_RST = cfg_t'({{3{32'(0)}}, DIR_Z_RST, 16'(0), 16'(0), 17'(0)});

  // stage 1: differences against the origin
  typedef struct packed {
    coord_t [2:0] c;
    scl_t   [2:0] g;    // c*one - o
    scl_t   [2:0] e;    // distance above inset lower bound
    scl_t   [2:0] f;    // distance below inset upper bound
    scl_t   [5:0] num;  // plane numerator, sign folded in
    den_t   [2:0] den;  // |d|
    logic   [2:0] dz;
  } s1_t;

  // stage 2: products
  typedef struct packed {
    coord_t [2:0]      c;
    prd_t   [2:0]      gd;
    prd_t   [2:0][1:0] ed;
    prd_t   [2:0][1:0] fd;
    prd_t   [5:0][1:0] ndp;
    logic   [5:0]      num_ok;
    logic   [2:0]      dz;
  } s2_t;

  // stage 3: face tests and distances
  typedef struct packed {
    coord_t [2:0] c;
    sum_t         cdist;
    sum_t   [5:0] ndist;
    logic   [5:0] hit;
  } s3_t;

  // axis normal to face: 0,1 -> z; 2,3 -> y; 4,5 -> x
  function automatic logic [1:0] face_axis(input logic [2:0] f);
    face_axis = 2'd2 - f[2:1];
  endfunction

  function automatic logic [1:0] other_axis(input logic [1:0] a, input logic j);
    if (!j) begin
      other_axis = (a == 2'd0) ? 2'd1 : 2'd0;
    end else begin
      other_axis = (a == 2'd2) ? 2'd1 : 2'd2;
    end
  endfunction

endpackage

/* rtl/core/rvfp_prep.sv */
module rvfp_prep (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_v,
  input  rvfp_pkg::in_word_t  din,
  input  rvfp_pkg::cfg_t      cfg,
  output logic                v_r,
  output rvfp_pkg::s1_t       q_r
);

  localparam int SW = rvfp_pkg::SCL_W;
  localparam logic signed [SW-1:0] ONE = {{(SW-1){1'b0}}, 1'b1} << rvfp_pkg::FRAC_BITS;

  rvfp_pkg::s1_t q_nxt;
  rvfp_pkg::coord_t [2:0] c;
  logic signed [SW-1:0] cw, ow, mw, gs, pl;
  logic signed [rvfp_pkg::DEN_W-1:0] dw;
  logic [1:0] ax;

  assign c = {din.cube_z, din.cube_y, din.cube_x};

  always_comb begin
    q_nxt = q_r;
    q_nxt.c = c;
    mw = SW'($signed({1'b0, cfg.margin}));
    for (int k = 0; k < 3; k++) begin
      cw = SW'($signed(c[k]));
      ow = SW'($signed(cfg.org[k]));
      gs = (cw <<< rvfp_pkg::FRAC_BITS) - ow;
      q_nxt.g[k] = gs;
      q_nxt.e[k] = ONE - mw - gs;
      q_nxt.f[k] = ONE - mw + gs;
      dw = rvfp_pkg::DEN_W'($signed(cfg.dir[k]));
      q_nxt.den[k] = dw[rvfp_pkg::DEN_W-1] ? -dw : dw;
      q_nxt.dz[k] = (cfg.dir[k] == '0);
    end
    for (int f = 0; f < 6; f++) begin
      ax = rvfp_pkg::face_axis(3'(f));
      cw = SW'($signed(c[ax]));
      ow = SW'($signed(cfg.org[ax]));
      gs = (cw <<< rvfp_pkg::FRAC_BITS) - ow;
      pl = (f % 2 == 1) ? gs + ONE : gs - ONE;
      q_nxt.num[f] = cfg.dir[ax][rvfp_pkg::DIR_BITS-1] ? -pl : pl;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

endmodule

/* rtl/core/rvfp_mul.sv */
module rvfp_mul (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_v,
  input  rvfp_pkg::s1_t  s1,
  input  rvfp_pkg::cfg_t cfg,
  output logic           v_r,
  output rvfp_pkg::s2_t  q_r
);

  rvfp_pkg::s2_t q_nxt;
  logic [1:0] ax, k;

  always_comb begin
    q_nxt = q_r;
    q_nxt.c  = s1.c;
    q_nxt.dz = s1.dz;
    for (int i = 0; i < 3; i++) begin
      q_nxt.gd[i] = $signed(s1.g[i]) * $signed(cfg.dir[i]);
      for (int j = 0; j < 2; j++) begin
        k = rvfp_pkg::other_axis(2'(i), 1'(j));
        q_nxt.ed[i][j] = $signed(s1.e[k]) * $signed(s1.den[i]);
        q_nxt.fd[i][j] = $signed(s1.f[k]) * $signed(s1.den[i]);
      end
    end
    for (int f = 0; f < 6; f++) begin
      ax = rvfp_pkg::face_axis(3'(f));
      q_nxt.num_ok[f] = !s1.num[f][rvfp_pkg::SCL_W-1];
      for (int j = 0; j < 2; j++) begin
        k = rvfp_pkg::other_axis(ax, 1'(j));
        q_nxt.ndp[f][j] = $signed(s1.num[f]) * $signed(cfg.dir[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

endmodule

/* rtl/core/rvfp_test.sv */
module rvfp_test (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_v,
  input  rvfp_pkg::s2_t  s2,
  input  rvfp_pkg::cfg_t cfg,
  output logic           v_r,
  output rvfp_pkg::s3_t  q_r
);

  localparam int UW = rvfp_pkg::SUM_W;

  rvfp_pkg::s3_t q_nxt;
  logic signed [UW-1:0] cd, lo_s, hi_s, step;
  logic [1:0] ax;
  logic ok;

  always_comb begin
    q_nxt = q_r;
    q_nxt.c = s2.c;
    cd = UW'($signed(s2.gd[0])) + UW'($signed(s2.gd[1])) + UW'($signed(s2.gd[2]));
    q_nxt.cdist = cd;
    for (int f = 0; f < 6; f++) begin
      ax = rvfp_pkg::face_axis(3'(f));
      ok = !s2.dz[ax] && s2.num_ok[f];
      for (int j = 0; j < 2; j++) begin
        lo_s = UW'($signed(s2.ed[ax][j])) + UW'($signed(s2.ndp[f][j]));
        hi_s = UW'($signed(s2.fd[ax][j])) - UW'($signed(s2.ndp[f][j]));
        ok = ok && (lo_s > 0) && (hi_s > 0);
      end
      q_nxt.hit[f] = ok;
      // neighbor center sits two units along the face normal
      step = UW'($signed(cfg.dir[ax])) <<< (rvfp_pkg::FRAC_BITS + 1);
      q_nxt.ndist[f] = (f % 2 == 1) ? cd + step : cd - step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

endmodule

/* rtl/core/rvfp_pick.sv */
module rvfp_pick (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_v,
  input  rvfp_pkg::s3_t       s3,
  output logic                v_r,
  output rvfp_pkg::out_word_t q_r
);

  localparam int SHW = rvfp_pkg::SUM_W - rvfp_pkg::DIR_FRAC;
  localparam int DB  = rvfp_pkg::DIST_BITS;

  rvfp_pkg::out_word_t q_nxt;
  logic [2:0] best;
  rvfp_pkg::sum_t bd;
  logic [SHW-1:0] sh;
  logic [1:0] ax;
  rvfp_pkg::nb_t [2:0] nb;

  always_comb begin
    best = rvfp_pkg::FACE_NONE;
    bd = '0;
    for (int f = 0; f < 6; f++) begin
      if (s3.hit[f] && ($signed(s3.ndist[f]) > 0) &&
          (best == rvfp_pkg::FACE_NONE || $signed(s3.ndist[f]) < $signed(bd))) begin
        best = 3'(f);
        bd = s3.ndist[f];
      end
    end

    sh = s3.cdist[rvfp_pkg::SUM_W-1:rvfp_pkg::DIR_FRAC];
    q_nxt.hit = |s3.hit;
    if ($signed(s3.cdist) > 0 && !(|sh[SHW-1:DB])) begin
      q_nxt.center_distance = sh[DB-1:0];
    end else begin
      q_nxt.center_distance = '1;
    end

    ax = rvfp_pkg::face_axis(best);
    for (int k = 0; k < 3; k++) begin
      nb[k] = rvfp_pkg::NB_BITS'($signed(s3.c[k]));
      if (best == rvfp_pkg::FACE_NONE) begin
        nb[k] = '0;
      end else if (ax == 2'(k)) begin
        nb[k] = best[0] ? nb[k] + rvfp_pkg::NB_BITS'(2) : nb[k] - rvfp_pkg::NB_BITS'(2);
      end
    end
    q_nxt.face_index = best;
    q_nxt.neighbor_x = nb[0];
    q_nxt.neighbor_y = nb[1];
    q_nxt.neighbor_z = nb[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

endmodule

/* rtl/core/ray_voxel_face_pick.sv */
// Ray against a cube of edge 2 centered on an integer cell. Software loads
// the ray (Q16.16 origin, unit Q2.14 direction, Q1.16 edge margin) through
// the cfg port while no word is in flight; each input word then names one
// cube center and yields exactly one result word: the hit flag, the
// projected center distance (saturated when not positive or too large), the
// nearest hit face whose neighbor lies ahead, and that neighbor cell.
// Throughput is one word per clock while out_stall is low. A word passes the
// four register stages (difference prep, multiply bank, face compare, face
// select with output register) in order. Each stage holds its word under
// stall and fills bubbles, so new words are accepted while a finished word
// waits at the output. All tests are exact integer compares.

`include "ray_voxel_face_pick_defines.svh"

module ray_voxel_face_pick (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // input words: cube center
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  rvfp_pkg::in_word_t                     in_data,
  // result words
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output rvfp_pkg::out_word_t                    out_data,
  // register writes
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [rvfp_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [rvfp_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

  rvfp_pkg::cfg_t cfg_r, cfg_nxt;
  rvfp_pkg::s1_t  s1;
  rvfp_pkg::s2_t  s2;
  rvfp_pkg::s3_t  s3;
  logic v1, v2, v3;
  logic en1, en2, en3, en4;

  // register file: writes always taken, unknown index ignored
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rvfp_pkg::REG_ORIGIN_X:    cfg_nxt.org[0] = cfg_data[rvfp_pkg::ORG_BITS-1:0];
        rvfp_pkg::REG_ORIGIN_Y:    cfg_nxt.org[1] = cfg_data[rvfp_pkg::ORG_BITS-1:0];
        rvfp_pkg::REG_ORIGIN_Z:    cfg_nxt.org[2] = cfg_data[rvfp_pkg::ORG_BITS-1:0];
        rvfp_pkg::REG_DIR_X:       cfg_nxt.dir[0] = cfg_data[rvfp_pkg::DIR_BITS-1:0];
        rvfp_pkg::REG_DIR_Y:       cfg_nxt.dir[1] = cfg_data[rvfp_pkg::DIR_BITS-1:0];
        rvfp_pkg::REG_DIR_Z:       cfg_nxt.dir[2] = cfg_data[rvfp_pkg::DIR_BITS-1:0];
        rvfp_pkg::REG_EDGE_MARGIN: cfg_nxt.margin = cfg_data[rvfp_pkg::MARGIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= rvfp_pkg::CFG_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // a stage loads when it is empty or its successor moves
  assign en4      = !out_valid || !out_stall;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_stall = !en1;

  rvfp_prep u_prep (
    .clk(clk), .rst_n(rst_n), .en(en1), .in_v(in_valid), .din(in_data),
    .cfg(cfg_r), .v_r(v1), .q_r(s1)
  );

  rvfp_mul u_mul (
    .clk(clk), .rst_n(rst_n), .en(en2), .in_v(v1), .s1(s1),
    .cfg(cfg_r), .v_r(v2), .q_r(s2)
  );

  rvfp_test u_test (
    .clk(clk), .rst_n(rst_n), .en(en3), .in_v(v2), .s2(s2),
    .cfg(cfg_r), .v_r(v3), .q_r(s3)
  );

  rvfp_pick u_pick (
    .clk(clk), .rst_n(rst_n), .en(en4), .in_v(v3), .s3(s3),
    .v_r(out_valid), .q_r(out_data)
  );

  // a chosen face is always a hit face
  `RVFP_ASSERT_IMPL(a_face_implies_hit, clk, rst_n,
    out_valid && out_data.face_index != rvfp_pkg::FACE_NONE, out_data.hit)
  // no chosen face leaves the neighbor at zero
  `RVFP_ASSERT_IMPL(a_none_zero_nb, clk, rst_n,
    out_valid && out_data.face_index == rvfp_pkg::FACE_NONE,
    out_data.neighbor_x == '0 && out_data.neighbor_y == '0 && out_data.neighbor_z == '0)
  // full pipe behind a stalled output pushes back on the input
  `RVFP_ASSERT_IMPL(a_full_stalls, clk, rst_n,
    out_valid && out_stall && v1 && v2 && v3, in_stall)
  // an accepted word lands in the first stage
  `RVFP_ASSERT_NEXT(a_accept_lands, clk, rst_n, in_valid && !in_stall, v1)

endmodule
